/* design/cgihbs_pkg.sv */
// Package for the CGI header block scanner.
// Holds the scan phase type, the state and step structs and the byte classes.
// No dependencies.
package cgihbs_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int LEN_W          = 16;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        PH_LINE_START = 3'd0,
        PH_LONE_CR    = 3'd1,
        PH_NAME       = 3'd2,
        PH_VALUE      = 3'd3,
        PH_VALUE_CR   = 3'd4,
        PH_DECIDED    = 3'd5
    } t_phase;

    typedef struct packed {
        t_phase phase;
        logic   name_seen;
        logic   header_seen;
    } t_scan_state;

    typedef struct packed {
        logic decided;
        logic found;
        logic count_inc;
    } t_step_status;

    // Token characters: letters, digits and !#$%&'*+-.^_`|~
    function automatic logic is_token(input logic [7:0] c);
        logic r;
        r = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A))
            || ((c >= 8'h61) && (c <= 8'h7A));
        case (c)
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
            8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: r = 1'b1;
            default: ;
        endcase
        return r;
    endfunction

endpackage

/* design/cgihbs_in_if.sv */
// Input channel of the header block scanner: one stream byte per beat.
// Depends on nothing.
interface cgihbs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

/* design/cgihbs_out_if.sv */
// Result channel of the header block scanner: one decision per beat.
// Depends on nothing.
interface cgihbs_out_if;
    logic        valid;
    logic        ready;
    logic        block_found;
    logic [15:0] block_length;

    modport source (output valid, output block_found, output block_length, input ready);
    modport sink   (input valid, input block_found, input block_length, output ready);
endinterface

/* design/cgihbs_step.sv */
// Per-byte next-state logic of the header block scanner.
// Depends on cgihbs_pkg.
module cgihbs_step
    import cgihbs_pkg::*;
(
    input  t_scan_state  i_state,
    input  logic         i_at_limit,
    input  logic [7:0]   i_byte,
    input  logic         i_last,
    output t_scan_state  o_state,
    output t_step_status o_status
);

    logic        tok;
    logic        dec;
    logic        fnd;
    t_scan_state nxt;

    assign tok = is_token(i_byte);

    always_comb begin
        nxt = i_state;
        dec = 1'b0;
        fnd = 1'b0;
        o_status.count_inc = 1'b0;
        if (i_state.phase != PH_DECIDED) begin
            if (i_at_limit) begin
                dec = 1'b1;
            end else begin
                o_status.count_inc = 1'b1;
                case (i_state.phase)
                    PH_LINE_START, PH_LONE_CR: begin
                        if (i_byte == CH_LF) begin
                            dec = 1'b1;
                            fnd = i_state.header_seen;
                        end else if (i_state.phase == PH_LONE_CR) begin
                            dec = 1'b1;
                        end else if (i_byte == CH_CR) begin
                            nxt.phase = PH_LONE_CR;
                        end else if (tok) begin
                            nxt.phase     = PH_NAME;
                            nxt.name_seen = 1'b1;
                        end else begin
                            dec = 1'b1;   // colon or other non-token byte
                        end
                    end
                    PH_NAME: begin
                        if (i_byte == CH_COLON) begin
                            if (i_state.name_seen) nxt.phase = PH_VALUE;
                            else dec = 1'b1;
                        end else if (tok) begin
                            nxt.name_seen = 1'b1;
                        end else begin
                            dec = 1'b1;
                        end
                    end
                    PH_VALUE, PH_VALUE_CR: begin
                        if (i_byte == CH_LF) begin
                            nxt.header_seen = 1'b1;
                            nxt.name_seen   = 1'b0;
                            nxt.phase       = PH_LINE_START;
                        end else if (i_byte == CH_NUL) begin
                            dec = 1'b1;
                        end else if (i_byte == CH_CR) begin
                            nxt.phase = PH_VALUE_CR;
                        end else if (i_state.phase == PH_VALUE_CR &&
                                     i_byte != CH_SPACE && i_byte != CH_TAB) begin
                            dec = 1'b1;
                        end
                    end
                    default: begin
                        dec = 1'b1;
                    end
                endcase
            end
            // last byte with no decision yet; a trailing lone CR still ends the block
            if (!dec && i_last) begin
                dec = 1'b1;
                fnd = (nxt.phase == PH_LONE_CR) && nxt.header_seen;
            end
            if (dec) nxt.phase = PH_DECIDED;
        end
        if (i_last) begin
            nxt.phase       = PH_LINE_START;
            nxt.name_seen   = 1'b0;
            nxt.header_seen = 1'b0;
        end
        o_state          = nxt;
        o_status.decided = dec;
        o_status.found   = fnd;
    end

endmodule

/* design/cgi_header_block_scanner.sv */
// CGI response header block scanner: takes one byte per cycle and reports
// the length of the leading name:value header block once it is terminated.
// Depends on cgihbs_pkg, cgihbs_in_if, cgihbs_out_if and cgihbs_step.
//
// One byte is accepted every cycle while the result register is empty or being
// drained; the scan state and byte counter update in the same cycle, and a
// decision is written to the result register, visible in the cycle after the
// deciding byte. Throughput is one byte per cycle while the result register is
// free; the single register stage lies between the byte classifier and the result.
// The byte count saturates at 2^min(COUNT_BITS,16)-1; a byte beyond that
// decides the buffer as not found.
module cgi_header_block_scanner
    import cgihbs_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    cgihbs_in_if.sink           i_item,
    cgihbs_out_if.source        o_result
);

    localparam int CNT_W = (COUNT_BITS > LEN_W) ? LEN_W : COUNT_BITS;

    t_scan_state  r_state;
    t_scan_state  n_state;
    t_step_status status;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] count_inc;
    logic             at_limit;
    logic             in_fire;

    logic             r_out_valid;
    logic             r_found;
    logic [LEN_W-1:0] r_length;

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign in_fire      = i_item.valid && i_item.ready;
    assign at_limit     = &r_count;
    assign count_inc    = r_count + CNT_W'(1);

    cgihbs_step u_step (
        .i_state    (r_state),
        .i_at_limit (at_limit),
        .i_byte     (i_item.data_byte),
        .i_last     (i_item.end_of_buffer),
        .o_state    (n_state),
        .o_status   (status)
    );

    always_comb begin
        n_count = r_count;
        if (i_item.end_of_buffer) n_count = '0;
        else if (status.count_inc) n_count = count_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= PH_LINE_START;
            r_state.name_seen   <= 1'b0;
            r_state.header_seen <= 1'b0;
            r_count             <= '0;
            r_out_valid         <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
                r_count <= n_count;
            end
            if (in_fire && status.decided) r_out_valid <= 1'b1;
            else if (o_result.ready)       r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && status.decided) begin
            r_found  <= status.found;
            r_length <= status.found ? LEN_W'(count_inc) : '0;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.block_found  = r_found;
    assign o_result.block_length = r_length;

endmodule

/* design/cgihbs_checker.sv */
// Port-level checks for the header block scanner, bound to the top level.
// Depends on cgi_header_block_scanner.
module cgihbs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_found,
    input logic [15:0] i_length
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_found) && $stable(i_length))
        else $error("result changed while stalled");

    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_found |-> i_length == 16'd0)
        else $error("not-found result with nonzero length");

    // shortest block is a one-char name, colon, LF and a terminating line
    a_min_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_found |-> i_length >= 16'd4)
        else $error("found block too short");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind cgi_header_block_scanner cgihbs_checker u_cgihbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_found     (o_result.block_found),
    .i_length    (o_result.block_length)
);

/* verif/cgi_header_block_scanner_test.sv */
// Self-checking testbench for cgi_header_block_scanner: directed header blocks
// and random byte streams under three idle mixes.
// Depends on cgihbs_pkg, cgihbs_in_if, cgihbs_out_if and the scanner RTL.
module cgi_header_block_scanner_test
    import cgihbs_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int COUNT_MAX   = (1 << ((COUNT_BITS_DEF > LEN_W) ? LEN_W : COUNT_BITS_DEF)) - 1;

    typedef struct {
        logic        found;
        logic [15:0] length;
    } t_decision;

    logic i_clk;
    logic i_rst_n;

    cgihbs_in_if  byte_if();
    cgihbs_out_if result_if();

    cgi_header_block_scanner u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (byte_if),
        .o_result (result_if)
    );

    // scanner state mirror
    t_phase sc_phase;
    logic   sc_name_seen;
    logic   sc_hdr_seen;
    int     sc_count;

    t_decision   pending_decisions[$];
    t_decision   oldest;
    logic [7:0]  stream_q[$];

    int src_idle_pct;
    int rcv_stall_pct;
    int cycle_count;
    int mismatches;
    int total_bytes;
    int buffers_done;
    int blocks_found;
    int blocks_rejected;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("cgi_header_block_scanner_test failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        result_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    function automatic bit is_name_char(input logic [7:0] c);
        string specials = "!#$%&'*+-.^_|~";
        if (c == 8'h60) return 1'b1;   // backtick
        for (int i = 0; i < specials.len(); i++)
            if (specials[i] == c) return 1'b1;
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    task automatic clear_scan();
        sc_phase     = PH_LINE_START;
        sc_name_seen = 1'b0;
        sc_hdr_seen  = 1'b0;
        sc_count     = 0;
    endtask

    // Advance the mirror by one beat and queue the decision it produces, if any.
    task automatic predict_scan(input logic [7:0] c, input logic last);
        logic        decided;
        logic        found;
        logic [15:0] length;
        decided = 1'b0;
        found   = 1'b0;
        length  = '0;
        if (sc_phase != PH_DECIDED) begin
            if (sc_count >= COUNT_MAX) begin
                decided = 1'b1;
            end else begin
                sc_count++;
                case (sc_phase)
                    PH_LINE_START, PH_LONE_CR: begin
                        if (c == CH_LF) begin
                            decided = 1'b1;
                            if (sc_hdr_seen) begin
                                found  = 1'b1;
                                length = sc_count[15:0];
                            end
                        end else if (sc_phase == PH_LONE_CR) begin
                            decided = 1'b1;
                        end else if (c == CH_CR) begin
                            sc_phase = PH_LONE_CR;
                        end else if (c == CH_COLON) begin
                            decided = 1'b1;
                        end else if (is_name_char(c)) begin
                            sc_phase     = PH_NAME;
                            sc_name_seen = 1'b1;
                        end else begin
                            decided = 1'b1;
                        end
                    end
                    PH_NAME: begin
                        if (c == CH_COLON) begin
                            if (sc_name_seen) sc_phase = PH_VALUE;
                            else decided = 1'b1;
                        end else if (is_name_char(c)) begin
                            sc_name_seen = 1'b1;
                        end else begin
                            decided = 1'b1;
                        end
                    end
                    PH_VALUE, PH_VALUE_CR: begin
                        if (c == CH_LF) begin
                            sc_hdr_seen  = 1'b1;
                            sc_name_seen = 1'b0;
                            sc_phase     = PH_LINE_START;
                        end else if (c == CH_NUL) begin
                            decided = 1'b1;
                        end else if (c == CH_CR) begin
                            sc_phase = PH_VALUE_CR;
                        end else if (sc_phase == PH_VALUE_CR && c != CH_SPACE && c != CH_TAB) begin
                            decided = 1'b1;
                        end
                    end
                    default: decided = 1'b1;
                endcase
            end
            // lone CR as the final byte still terminates the block
            if (!decided && last) begin
                decided = 1'b1;
                if (sc_phase == PH_LONE_CR && sc_hdr_seen) begin
                    found  = 1'b1;
                    length = sc_count[15:0];
                end
            end
            if (decided) sc_phase = PH_DECIDED;
        end
        if (decided) pending_decisions.push_back('{found, length});
        if (last) clear_scan();
    endtask

    // Input and output beats are handled in one process, input first.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (byte_if.valid && byte_if.ready) begin
                predict_scan(byte_if.data_byte, byte_if.end_of_buffer);
                if (byte_if.end_of_buffer) buffers_done++;
            end
            if (result_if.valid && result_if.ready) begin
                if (pending_decisions.size() == 0) begin
                    report_mismatch($sformatf("unexpected result found=%0b length=%0d",
                        result_if.block_found, result_if.block_length));
                end else begin
                    oldest = pending_decisions.pop_front();
                    if (result_if.block_found !== oldest.found)
                        report_mismatch($sformatf("block_found %b, want %b",
                            result_if.block_found, oldest.found));
                    if (result_if.block_length !== oldest.length)
                        report_mismatch($sformatf("block_length %0d, want %0d",
                            result_if.block_length, oldest.length));
                    if (oldest.found) blocks_found++;
                    else blocks_rejected++;
                end
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_beat(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            byte_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_if.valid         <= 1'b1;
        byte_if.data_byte     <= b;
        byte_if.end_of_buffer <= last;
        @(posedge i_clk);
        while (!byte_if.ready) @(posedge i_clk);
        total_bytes++;
        @(negedge i_clk);
    endtask

    task automatic send_stream();
        foreach (stream_q[i]) send_beat(stream_q[i], i == stream_q.size() - 1);
        stream_q.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) stream_q.push_back(s[i]);
        send_stream();
    endtask

    function automatic logic [7:0] rand_value_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CH_CR || c == CH_LF);
        return c;
    endfunction

    function automatic logic [7:0] rand_name_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(33, 126)); while (!is_name_char(c));
        return c;
    endfunction

    // \015 is CR
    task automatic test_directed_cases();
        send_text("Ab-9:v\n\n");
        send_text("\n");                    // blank line, no header
        send_text("x:y\n\015");             // lone CR as last byte
        send_text("\015");
        send_text(":v\n");                  // empty name
        send_text("a b:c\n");               // space in name
        send_text("Name");                  // no colon, buffer ends
        stream_q = '{"a", CH_COLON, CH_NUL, CH_LF};
        send_stream();
        send_text("a:x\015 \t\015\n\015\n"); // CR followed by blanks only is fine
        send_text("a:x\015y\n");
        send_text("a:b\n\015X");
        send_text("a:b\n\015\015");
        send_text("a:b\n");                 // header but no blank line
        send_text("\nbody");                // bytes after decision ignored
        stream_q = '{8'h7E, 8'h60, 8'h7C, CH_COLON, 8'h80, 8'h7F, CH_LF, CH_LF};
        send_stream();
        stream_q = '{"a", 8'hFF, CH_COLON, CH_LF};
        send_stream();
    endtask

    task automatic test_random_buffers(input int n_bytes);
        int start;
        int kind;
        int n_hdr;
        int term;
        start = total_bytes;
        while (total_bytes - start < n_bytes) begin
            kind = $urandom_range(9);
            if (kind == 0) begin
                repeat ($urandom_range(1, 12)) stream_q.push_back(8'($urandom_range(255)));
            end else begin
                n_hdr = $urandom_range(0, 4);
                repeat (n_hdr) begin
                    repeat ($urandom_range(1, 6)) stream_q.push_back(rand_name_byte());
                    stream_q.push_back(CH_COLON);
                    repeat ($urandom_range(0, 10)) stream_q.push_back(rand_value_byte());
                    if ($urandom_range(3) == 0) begin
                        stream_q.push_back(CH_CR);
                        repeat ($urandom_range(0, 2)) begin
                            case ($urandom_range(2))
                                0: stream_q.push_back(CH_SPACE);
                                1: stream_q.push_back(CH_TAB);
                                default: stream_q.push_back(CH_CR);
                            endcase
                        end
                    end
                    stream_q.push_back(CH_LF);
                end
                term = $urandom_range(3);
                case (term)
                    0: stream_q.push_back(CH_LF);
                    1: begin
                        stream_q.push_back(CH_CR);
                        stream_q.push_back(CH_LF);
                    end
                    2: stream_q.push_back(CH_CR);
                    default: ;
                endcase
                if (term != 2)
                    repeat ($urandom_range(0, 6)) stream_q.push_back(8'($urandom_range(255)));
                if (stream_q.size() == 0) stream_q.push_back(CH_LF);
                // broken sequence: overwrite one byte with anything
                if (kind >= 7)
                    stream_q[$urandom_range(stream_q.size() - 1)] = 8'($urandom_range(255));
            end
            send_stream();
        end
    endtask

    initial begin
        cycle_count     = 0;
        mismatches      = 0;
        total_bytes     = 0;
        buffers_done    = 0;
        blocks_found    = 0;
        blocks_rejected = 0;
        src_idle_pct    = 8;
        rcv_stall_pct   = 67;
        clear_scan();
        i_rst_n                = 1'b0;
        byte_if.valid          <= 1'b0;
        byte_if.data_byte      <= '0;
        byte_if.end_of_buffer  <= 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_random_buffers(360);
        src_idle_pct  = 67;
        rcv_stall_pct = 8;
        test_random_buffers(350);
        src_idle_pct  = 0;
        rcv_stall_pct = 0;
        test_random_buffers(360);

        byte_if.valid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_decisions.size() != 0)
            report_mismatch($sformatf("%0d decisions never arrived", pending_decisions.size()));

        $display("Covered %0d bytes in %0d buffers: %0d header blocks found, %0d rejected.",
            total_bytes, buffers_done, blocks_found, blocks_rejected);
        $display("Directed cases and random streams under three idle mixes.");
        if (mismatches == 0) begin
            $display("cgi_header_block_scanner_test passed");
        end else begin
            $display("cgi_header_block_scanner_test failed");
        end
        $finish;
    end

endmodule
